/* rtl/efrc8_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efrc8_pkg
// Shared constants, result codes and the CRC-8 byte step for the escaped
// frame receiver.
// ----------------------------------------------------------------------------
package efrc8_pkg;

    localparam int STORE_DEPTH = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 6;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_PRESET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

    localparam logic [7:0]  START_BYTE_RST    = 8'hA1;
    localparam logic [7:0]  END_BYTE_RST      = 8'hA2;
    localparam logic [7:0]  ESCAPE_BYTE_RST   = 8'hA3;
    localparam logic [7:0]  CRC_PRESET_RST    = 8'h00;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam logic [7:0] ESCAPE_OR_MASK = 8'hA0;
    localparam logic [7:0] CRC_POLY       = 8'h07;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CRC_BAD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    // One byte through the CRC-8 register, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/escaped_frame_receiver_crc8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc8
// Byte-stuffed frame receiver with CRC-8 check and a tick-driven timeout.
// ----------------------------------------------------------------------------
// A user should know first: the block takes one transaction at a time on the
// slave side. After a tick report (tuser = 1) the block is ready again, and
// after a received byte (tuser = 0) too, unless the byte ends a frame or
// overflows the store. An end byte with a non-empty store starts the CRC
// sequencer, which folds one stored byte per cycle through the package's
// CRC-8 byte step (one frame store read per cycle), and a good frame then
// streams its payload out at one byte per cycle while the master side keeps
// tready high. Flag results (overflow, CRC mismatch, good empty frame) go out
// through the output register. The output register lets the next slave
// transaction be accepted while the last result still waits on the master
// side. The frame store has no reset.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc8 #(
    parameter int STORE_DEPTH = efrc8_pkg::STORE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration write port.
    input  wire                                 i_cfg_we,
    input  wire  [efrc8_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire  [efrc8_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Slave side.
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [efrc8_pkg::S_DATA_W-1:0]      i_s_tdata,  // rx_byte[7:0], elapsed_ticks[23:8]
    input  wire                                 i_s_tuser,  // cmd
    // Master side.
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [efrc8_pkg::M_DATA_W-1:0]      o_m_tdata,  // payload_byte[7:0], frame_length[13:8]
    output logic [efrc8_pkg::KIND_W-1:0]        o_m_tuser,  // kind
    output logic                                o_m_tlast   // last
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int LW = efrc8_pkg::LEN_W;
    localparam int KW = efrc8_pkg::KIND_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CRC  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_FLAG = 2'd3;

    // Receiver modes.
    localparam logic [1:0] M_IDLE   = 2'd0;
    localparam logic [1:0] M_RECV   = 2'd1;
    localparam logic [1:0] M_ESCAPE = 2'd2;
    localparam logic [1:0] M_END    = 2'd3;

    // Configuration registers.
    logic [7:0]  r_start_byte;
    logic [7:0]  r_end_byte;
    logic [7:0]  r_escape_byte;
    logic [7:0]  r_crc_preset;
    logic [15:0] r_timeout_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte    <= efrc8_pkg::START_BYTE_RST;
            r_end_byte      <= efrc8_pkg::END_BYTE_RST;
            r_escape_byte   <= efrc8_pkg::ESCAPE_BYTE_RST;
            r_crc_preset    <= efrc8_pkg::CRC_PRESET_RST;
            r_timeout_ticks <= efrc8_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                efrc8_pkg::REG_START_BYTE:    r_start_byte    <= i_cfg_data[7:0];
                efrc8_pkg::REG_END_BYTE:      r_end_byte      <= i_cfg_data[7:0];
                efrc8_pkg::REG_ESCAPE_BYTE:   r_escape_byte   <= i_cfg_data[7:0];
                efrc8_pkg::REG_CRC_PRESET:    r_crc_preset    <= i_cfg_data[7:0];
                efrc8_pkg::REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control and working registers.
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_timeout, n_timeout;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_len, n_len;
    logic [7:0]    r_crc, n_crc;
    logic [KW-1:0] r_flag_kind, n_flag_kind;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic [KW-1:0] r_out_kind, n_out_kind;
    logic [7:0]    r_out_byte, n_out_byte;
    logic [LW-1:0] r_out_len, n_out_len;
    logic          r_out_last, n_out_last;

    // Frame store.
    logic [7:0]    r_store [STORE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] n_rd_addr;
    logic          n_wr_en;
    logic [AW-1:0] n_wr_addr;
    logic [7:0]    n_wr_data;

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_store[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= r_store[n_rd_addr];
    end

    logic          s_accept;
    logic          out_free;
    logic [7:0]    rx_byte;
    logic [15:0]   elapsed;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] idx_inc;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign rx_byte    = i_s_tdata[7:0];
    assign elapsed    = i_s_tdata[23:8];
    assign count_dec  = r_count - CW'(1);
    assign idx_inc    = r_idx + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_timeout   = r_timeout;
        n_idx       = r_idx;
        n_len       = r_len;
        n_crc       = r_crc;
        n_flag_kind = r_flag_kind;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        n_rd_addr   = '0;
        n_wr_en     = 1'b0;
        n_wr_addr   = r_count[AW-1:0];
        n_wr_data   = rx_byte;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser) begin
                        // Tick report: count the timeout down.
                        if (r_timeout != 16'd0) begin
                            if (r_timeout > elapsed) begin
                                n_timeout = r_timeout - elapsed;
                            end else begin
                                n_timeout = 16'd0;
                                n_mode    = M_IDLE;
                                n_count   = '0;
                            end
                        end
                    end else if (r_mode == M_IDLE && rx_byte != r_start_byte) begin
                        // Line noise between frames is dropped.
                    end else if (r_count >= CW'(STORE_DEPTH)) begin
                        n_mode      = M_IDLE;
                        n_count     = '0;
                        n_flag_kind = efrc8_pkg::KIND_OVERFLOW;
                        n_state     = S_FLAG;
                    end else begin
                        n_timeout = r_timeout_ticks;
                        priority if (rx_byte == r_start_byte) begin
                            n_count = '0;
                            n_mode  = M_RECV;
                        end else if (rx_byte == r_end_byte) begin
                            n_mode = M_END;
                            if (r_count == '0) begin
                                n_mode      = M_IDLE;
                                n_flag_kind = efrc8_pkg::KIND_CRC_BAD;
                                n_state     = S_FLAG;
                            end else begin
                                // The last stored byte is the CRC; check the rest.
                                n_len     = count_dec[AW-1:0];
                                n_idx     = '0;
                                n_crc     = r_crc_preset;
                                n_rd_addr = '0;
                                n_state   = S_CRC;
                            end
                        end else if (rx_byte == r_escape_byte) begin
                            n_mode = M_ESCAPE;
                        end else if (r_mode == M_ESCAPE) begin
                            n_wr_en   = 1'b1;
                            n_wr_data = rx_byte | efrc8_pkg::ESCAPE_OR_MASK;
                            n_count   = r_count + CW'(1);
                            n_mode    = M_RECV;
                        end else if (r_mode == M_RECV) begin
                            n_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            // Ordinary byte after a completed frame.
                            n_mode  = M_IDLE;
                            n_count = '0;
                        end
                    end
                end
            end

            S_CRC: begin
                // r_rd_data holds store[r_idx].
                if (r_idx == r_len) begin
                    n_rd_addr = '0;
                    if (r_crc != r_rd_data) begin
                        n_mode      = M_IDLE;
                        n_count     = '0;
                        n_flag_kind = efrc8_pkg::KIND_CRC_BAD;
                        n_state     = S_FLAG;
                    end else begin
                        n_count = CW'(r_len);
                        n_idx   = '0;
                        if (r_len == '0) begin
                            n_flag_kind = efrc8_pkg::KIND_EMPTY;
                            n_state     = S_FLAG;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end else begin
                    n_crc     = efrc8_pkg::crc8_byte(r_crc, r_rd_data);
                    n_idx     = idx_inc;
                    n_rd_addr = idx_inc;
                end
            end

            S_EMIT: begin
                // r_rd_data holds store[r_idx]; advance only when the output
                // register takes it, else read the same entry again.
                n_rd_addr = r_idx;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = efrc8_pkg::KIND_PAYLOAD;
                    n_out_byte  = r_rd_data;
                    n_out_len   = LW'(r_len);
                    n_out_last  = (idx_inc == r_len);
                    n_idx       = idx_inc;
                    n_rd_addr   = idx_inc;
                    if (idx_inc == r_len) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_FLAG: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_flag_kind;
                    n_out_byte  = 8'd0;
                    n_out_len   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_IDLE;
            r_count     <= '0;
            r_timeout   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_timeout   <= n_timeout;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_crc       <= n_crc;
        r_flag_kind <= n_flag_kind;
        r_out_kind  <= n_out_kind;
        r_out_byte  <= n_out_byte;
        r_out_len   <= n_out_len;
        r_out_last  <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(efrc8_pkg::M_DATA_W - 8 - LW){1'b0}}, r_out_len, r_out_byte};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire
